/* design/sdt_pkg.sv */
package sdt_pkg;

    localparam int unsigned STEP_W = 8;

    // register word index on the config port
    localparam logic REG_RLL_MODE = 1'b0;

    typedef enum logic [2:0] {
        ACT_ADD_ENTERED = 3'd0,
        ACT_ADD_RAW     = 3'd1,
        ACT_DELETE      = 3'd2,
        ACT_CONVERT     = 3'd3,
        ACT_READ        = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_POST
    } state_t;

    typedef struct packed {
        logic [23:0]        cyl;
        logic [7:0]         hd;
        logic signed [31:0] bfi;
    } entry_t;

    typedef struct packed {
        logic              run;
        act_t              op;
        logic              rll;
        logic [STEP_W-1:0] step;
        logic [STEP_W-1:0] cnt;
        logic [STEP_W-1:0] idx;
    } ctrl_t;

    // true when a sorts strictly after b (cylinder, head, then signed bfi)
    function automatic logic entry_after(input entry_t a, input entry_t b);
        return {a.cyl, a.hd, ~a.bfi[31], a.bfi[30:0]} >
               {b.cyl, b.hd, ~b.bfi[31], b.bfi[30:0]};
    endfunction

    // d + d/2, truncating, saturated to 32 bits
    function automatic logic signed [31:0] scale_rll(input logic signed [31:0] d);
        logic signed [32:0] x;
        logic signed [32:0] h;
        logic signed [32:0] s;
        x = {d[31], d};
        h = $signed(x + 33'(d[31])) >>> 1;
        s = x + h;
        if (s[32] != s[31])
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return s[31:0];
    endfunction

    // d - d/3, truncating; magnitude never grows so no saturation needed
    function automatic logic signed [31:0] scale_plain(input logic signed [31:0] d);
        logic [31:0] mag;
        logic [63:0] prod;
        logic [30:0] q;
        mag  = d[31] ? (~d + 32'd1) : d;
        prod = {32'd0, mag} * 64'h0000_0000_AAAA_AAAB;
        q    = prod[63:33];
        return d[31] ? d + $signed({1'b0, q}) : d - $signed({1'b0, q});
    endfunction

endpackage

/* design/sdt_cell.sv */
module sdt_cell (
    input  logic            clk,
    input  logic            shift,
    input  sdt_pkg::entry_t d_in,
    output sdt_pkg::entry_t q
);
    import sdt_pkg::*;

    entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d_in;
        end
    end

    assign q = data_reg;

endmodule

/* design/sdt_head.sv */
module sdt_head (
    input  logic            clk,
    input  logic            rst_n,
    input  sdt_pkg::ctrl_t  ctrl,
    input  sdt_pkg::entry_t x,
    input  sdt_pkg::entry_t new_entry,
    output sdt_pkg::entry_t tail,
    output sdt_pkg::entry_t rd
);
    import sdt_pkg::*;

    entry_t hold_reg, hold_next;
    entry_t rd_reg, rd_next;
    logic   pre_reg, pre_next;

    logic   first;
    logic   valid_x;
    logic   pre_eff;
    logic   take_x;
    entry_t hold_eff;

    assign first    = (ctrl.step == '0);
    assign valid_x  = (ctrl.step < ctrl.cnt);
    assign pre_eff  = first | pre_reg;
    assign hold_eff = first ? new_entry : hold_reg;
    assign take_x   = pre_eff & valid_x & ~entry_after(x, new_entry);

    // entry at the head of the ring is processed and fed back to the tail
    always_comb
    begin
        tail      = x;
        hold_next = hold_reg;
        pre_next  = pre_reg;
        rd_next   = rd_reg;
        case (ctrl.op)
            ACT_ADD_ENTERED, ACT_ADD_RAW:
            begin
                // pass entries until the insertion point, then run as a delay line
                tail      = take_x ? x : hold_eff;
                hold_next = take_x ? hold_eff : x;
                pre_next  = take_x;
            end
            ACT_DELETE:
            begin
                // delay by one up to the deleted slot, which is dropped
                if (ctrl.step <= ctrl.idx)
                begin
                    tail      = hold_reg;
                    hold_next = x;
                end
            end
            ACT_CONVERT:
            begin
                if (valid_x)
                begin
                    tail.bfi = ctrl.rll ? scale_rll(x.bfi) : scale_plain(x.bfi);
                end
            end
            ACT_READ:
            begin
                if (ctrl.step == ctrl.idx)
                begin
                    rd_next = x;
                end
            end
            default:
            begin
                tail = x;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg <= 1'b0;
        end
        else if (ctrl.run)
        begin
            pre_reg <= pre_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.run)
        begin
            hold_reg <= hold_next;
            rd_reg   <= rd_next;
        end
    end

    assign rd = rd_reg;

endmodule

/* design/sorted_defect_table_core.sv */
// Sorted defect table: holds up to TABLE_DEPTH defect entries (cylinder, head,
// signed bfi) in ascending order in a ring of cells that rotates one position
// per clock while a transaction runs, through a single head unit. Add, convert
// and read take one full rotation plus accept and result, delete takes one
// extra ring step; a rejected add, an out-of-range index or an unused action
// skips the rotation. One transaction is worked at a time; the result register
// lets the next input be taken while a result is still waiting downstream.
module sorted_defect_table_core #(
    parameter int TABLE_DEPTH = 127
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [23:0]        cylinder,
    input  logic [7:0]         head,
    input  logic signed [31:0] bytes_from_index,
    input  logic [7:0]         entry_index,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [6:0]         entry_count,
    output logic [23:0]        read_cylinder,
    output logic [7:0]         read_head,
    output logic signed [31:0] read_bfi
);
    import sdt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   step_reg, step_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    act_t            op_reg, op_next;
    logic [7:0]      idx_reg, idx_next;
    status_t         stat_reg, stat_next;
    entry_t          entry_reg, entry_next;
    logic            rll_reg;

    logic            out_valid_reg, out_valid_next;
    logic [1:0]      status_out_reg;
    logic [6:0]      count_out_reg;
    entry_t          rd_out_reg, rd_out_next;

    logic            in_accept;
    logic            cfg_write;
    logic            last_step;
    logic            out_free;
    logic            rotate;
    act_t            act_in;
    logic            is_add, is_idx_op, full, bad_idx;

    ctrl_t           ctrl;
    entry_t          ring_q [TABLE_DEPTH];
    entry_t          tail;
    entry_t          rd;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == REG_RLL_MODE) ? {31'd0, rll_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rll_reg <= 1'b0;
        end
        else if (cfg_write && paddr[2] == REG_RLL_MODE)
        begin
            rll_reg <= pwdata[0];
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid & ~in_stall;
    assign out_free  = ~out_valid_reg | ~out_stall;

    assign act_in    = act_t'(action);
    assign is_add    = (act_in == ACT_ADD_ENTERED) || (act_in == ACT_ADD_RAW);
    assign is_idx_op = (act_in == ACT_DELETE) || (act_in == ACT_READ);
    assign full      = (cnt_reg >= CW'(TABLE_DEPTH));
    assign bad_idx   = (entry_index >= 8'(cnt_reg));
    assign rotate    = (is_add & ~full) | (is_idx_op & ~bad_idx) |
                       (act_in == ACT_CONVERT);

    assign last_step = (op_reg == ACT_DELETE) ? (step_reg == CW'(TABLE_DEPTH))
                                              : (step_reg == CW'(TABLE_DEPTH - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = rotate ? S_RUN : S_POST;
                end
            end
            S_RUN:
            begin
                if (last_step)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        stat_next      = stat_reg;
        entry_next     = entry_reg;
        out_valid_next = out_valid_reg & out_stall;
        rd_out_next    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    step_next      = '0;
                    op_next        = act_in;
                    idx_next       = entry_index;
                    entry_next.cyl = cylinder;
                    entry_next.hd  = head;
                    entry_next.bfi = (act_in == ACT_ADD_ENTERED && rll_reg)
                                     ? scale_rll(bytes_from_index) : bytes_from_index;
                    if (is_add && full)
                        stat_next = STAT_FULL;
                    else if (is_idx_op && bad_idx)
                        stat_next = STAT_RANGE;
                    else
                        stat_next = STAT_DONE;
                end
            end
            S_RUN:
            begin
                step_next = step_reg + CW'(1);
                if (last_step)
                begin
                    case (op_reg)
                        ACT_ADD_ENTERED, ACT_ADD_RAW: cnt_next = cnt_reg + CW'(1);
                        ACT_DELETE:                   cnt_next = cnt_reg - CW'(1);
                        default:                      cnt_next = cnt_reg;
                    endcase
                end
            end
            S_POST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
        if (op_reg == ACT_READ && stat_reg == STAT_DONE)
        begin
            rd_out_next = rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            op_reg        <= ACT_READ;
            stat_reg      <= STAT_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            stat_reg      <= stat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        entry_reg <= entry_next;
        if (state_reg == S_POST && out_free)
        begin
            status_out_reg <= stat_reg;
            count_out_reg  <= 7'(cnt_reg);
            rd_out_reg     <= rd_out_next;
        end
    end

    // ring of cells
    assign ctrl.run  = (state_reg == S_RUN);
    assign ctrl.op   = op_reg;
    assign ctrl.rll  = rll_reg;
    assign ctrl.step = STEP_W'(step_reg);
    assign ctrl.cnt  = STEP_W'(cnt_reg);
    assign ctrl.idx  = idx_reg;

    sdt_head u_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .x         (ring_q[0]),
        .new_entry (entry_reg),
        .tail      (tail),
        .rd        (rd)
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        if (i == TABLE_DEPTH - 1)
        begin : g_last
            sdt_cell u_cell (
                .clk   (clk),
                .shift (ctrl.run),
                .d_in  (tail),
                .q     (ring_q[i])
            );
        end
        else
        begin : g_mid
            sdt_cell u_cell (
                .clk   (clk),
                .shift (ctrl.run),
                .d_in  (ring_q[i + 1]),
                .q     (ring_q[i])
            );
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_out_reg;
    assign entry_count   = count_out_reg;
    assign read_cylinder = rd_out_reg.cyl;
    assign read_head     = rd_out_reg.hd;
    assign read_bfi      = rd_out_reg.bfi;

endmodule
